// ===== rtl/ace_pkg.sv =====
// Shared types and constants for the alarm compare and edit block
`default_nettype none

package ace_pkg;

    // Command codes carried by each input item
    typedef enum logic [1:0] {
        CMD_CHECK   = 2'd0,
        CMD_SAVE    = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_PREVIEW = 2'd3
    } cmd_t;

    // Save error codes: offending digit column
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_HOUR_TENS   = 3'd1;
    localparam logic [2:0] ERR_HOUR_ONES   = 3'd2;
    localparam logic [2:0] ERR_MINUTE_TENS = 3'd3;
    localparam logic [2:0] ERR_MINUTE_ONES = 3'd4;

    // Last triggered minute value meaning none
    localparam logic [10:0] NO_TRIGGER = 11'd2047;

    localparam logic [15:0] DELAY_RESET = 16'd1000;

    // One input item
    typedef struct packed {
        cmd_t        command;
        logic [31:0] now_ms;
        logic        rtc_ok;
        logic [4:0]  current_hour;
        logic [5:0]  current_minute;
        logic [3:0]  edit_hour_tens;
        logic [3:0]  edit_hour_ones;
        logic [3:0]  edit_minute_tens;
        logic [3:0]  edit_minute_ones;
    } ace_item_t;

    // One result item
    typedef struct packed {
        logic        ringing;
        logic        enabled;
        logic [15:0] alarm_display;
        logic [15:0] edit_display;
        logic [2:0]  error_column;
        logic        buzzer_start;
        logic        buzzer_stop;
    } ace_result_t;

endpackage

`default_nettype wire

// ===== rtl/ace_input_stage.sv =====
// Input register with stall back to the producer
`default_nettype none

module ace_input_stage
    import ace_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire ace_item_t in_item,
    input  wire logic      take,
    output logic           item_valid,
    output ace_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    ace_item_t item_reg;

    // Hold the item while the engine cannot take it
    assign in_stall   = valid_reg && !take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new item whenever the register is free or draining
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/ace_engine.sv =====
// Alarm state, time check, save validation and result formatting
`default_nettype none

module ace_engine
    import ace_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        fire,
    input  wire ace_item_t   item,
    output ace_result_t      result
);

    // Stored alarm digits (always a valid time, 24:00 folded to 00:00)
    logic [3:0]  a_ht_reg, a_ho_reg, a_mt_reg, a_mo_reg;
    logic [3:0]  a_ht_next, a_ho_next, a_mt_next, a_mo_next;
    logic        armed_reg, armed_next;
    logic        ring_reg, ring_next;
    logic [10:0] last_trig_reg, last_trig_next;
    logic [31:0] last_check_reg, last_check_next;
    logic [15:0] delay_reg;

    logic [7:0]  alarm_hour_bin;
    logic [7:0]  alarm_minute_bin;
    logic [10:0] cur_minute;
    logic [31:0] elapsed;
    logic        delay_done;
    logic        time_match;
    logic        zero_edit;
    logic        is24;
    logic [2:0]  err;
    logic        start;
    logic        stop;
    logic [3:0]  ht, ho, mt, mo;

    assign ht = item.edit_hour_tens;
    assign ho = item.edit_hour_ones;
    assign mt = item.edit_minute_tens;
    assign mo = item.edit_minute_ones;

    // Binary alarm time for the compare
    assign alarm_hour_bin   = {4'd0, a_ht_reg} * 8'd10 + {4'd0, a_ho_reg};
    assign alarm_minute_bin = {4'd0, a_mt_reg} * 8'd10 + {4'd0, a_mo_reg};
    assign cur_minute = {6'd0, item.current_hour} * 11'd60 + {5'd0, item.current_minute};
    assign elapsed    = item.now_ms - last_check_reg;
    assign delay_done = elapsed >= {16'd0, delay_reg};
    assign time_match = ({3'd0, item.current_hour} == alarm_hour_bin) &&
                        ({2'd0, item.current_minute} == alarm_minute_bin);

    assign zero_edit = (ht | ho | mt | mo) == 4'd0;
    assign is24      = (ht == 4'd2) && (ho == 4'd4);

    // Find the first offending save column
    always_comb
    begin
        priority if (ht > 4'd2)
            err = ERR_HOUR_TENS;
        else if (ho > 4'd9 || (ht == 4'd2 && ho > 4'd4))
            err = ERR_HOUR_ONES;
        else if (mt > 4'd5 || (is24 && mt != 4'd0))
            err = ERR_MINUTE_TENS;
        else if (mo > 4'd9 || (is24 && mo != 4'd0))
            err = ERR_MINUTE_ONES;
        else
            err = ERR_NONE;
    end

    // Next state and pulses for the current command
    always_comb
    begin
        a_ht_next       = a_ht_reg;
        a_ho_next       = a_ho_reg;
        a_mt_next       = a_mt_reg;
        a_mo_next       = a_mo_reg;
        armed_next      = armed_reg;
        ring_next       = ring_reg;
        last_trig_next  = last_trig_reg;
        last_check_next = last_check_reg;
        start           = 1'b0;
        stop            = 1'b0;
        result.error_column = ERR_NONE;

        unique case (item.command)
            CMD_CHECK:
            begin
                if (!ring_reg && armed_reg && delay_done)
                begin
                    last_check_next = item.now_ms;
                    if (item.rtc_ok && cur_minute != last_trig_reg && time_match)
                    begin
                        last_trig_next = cur_minute;
                        ring_next      = 1'b1;
                        start          = 1'b1;
                    end
                end
            end
            CMD_SAVE:
            begin
                result.error_column = err;
                if (err == ERR_NONE)
                begin
                    ring_next      = 1'b0;
                    stop           = 1'b1;
                    last_trig_next = NO_TRIGGER;
                    if (zero_edit)
                    begin
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        armed_next = 1'b1;
                        a_ht_next  = is24 ? 4'd0 : ht;
                        a_ho_next  = is24 ? 4'd0 : ho;
                        a_mt_next  = mt;
                        a_mo_next  = mo;
                    end
                end
            end
            CMD_DISABLE:
            begin
                a_ht_next      = 4'd0;
                a_ho_next      = 4'd0;
                a_mt_next      = 4'd0;
                a_mo_next      = 4'd0;
                armed_next     = 1'b0;
                ring_next      = 1'b0;
                last_trig_next = NO_TRIGGER;
                stop           = 1'b1;
            end
            CMD_PREVIEW:
            begin
                // Report only
            end
            default:
            begin
            end
        endcase

        // Format the result from the updated state
        result.ringing       = ring_next;
        result.enabled       = armed_next;
        result.alarm_display = armed_next ? {a_mo_next, a_mt_next, a_ho_next, a_ht_next}
                                          : 16'd0;
        if (zero_edit)
            result.edit_display = armed_next ? 16'h0042 : 16'd0;
        else
            result.edit_display = {mo, mt, ho, ht};
        result.buzzer_start = start;
        result.buzzer_stop  = stop;
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ht_reg       <= 4'd0;
            a_ho_reg       <= 4'd0;
            a_mt_reg       <= 4'd0;
            a_mo_reg       <= 4'd0;
            armed_reg      <= 1'b0;
            ring_reg       <= 1'b0;
            last_trig_reg  <= NO_TRIGGER;
            last_check_reg <= 32'd0;
        end
        else if (fire)
        begin
            a_ht_reg       <= a_ht_next;
            a_ho_reg       <= a_ho_next;
            a_mt_reg       <= a_mt_next;
            a_mo_reg       <= a_mo_next;
            armed_reg      <= armed_next;
            ring_reg       <= ring_next;
            last_trig_reg  <= last_trig_next;
            last_check_reg <= last_check_next;
        end
    end

    // Update delay register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            delay_reg <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ace_output_stage.sv =====
// Result register toward the consumer
`default_nettype none

module ace_output_stage
    import ace_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire ace_result_t result_in,
    output logic             take,
    output logic             out_valid,
    input  wire logic        out_stall,
    output ace_result_t      result_out
);

    logic        valid_reg;
    logic        valid_next;
    ace_result_t result_reg;

    // Free when empty or when the held item leaves this cycle
    assign take       = !valid_reg || !out_stall;
    assign valid_next = take ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

// ===== rtl/alarm_compare_and_edit.sv =====
// Top level of the alarm compare and edit block
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | command, now_ms, rtc_ok, clock, edit digits
//   out     | output    | out_valid/out_stall| ringing, enabled, displays, error, buzzer
//   cfg     | input     | cfg_we             | cfg_wdata = update delay in ms
//
// One item per cycle while neither channel stalls; a result is presented after its item passes
// the input register and then the result register, which is loaded together with the state update.
// Reset clears the alarm, disarms it and sets the update delay to 1000 ms.
// A stalled result holds in the result register; the input register keeps
// accepting until it is also full.
`default_nettype none

module alarm_compare_and_edit
    import ace_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] now_ms,
    input  wire logic        rtc_ok,
    input  wire logic [4:0]  current_hour,
    input  wire logic [5:0]  current_minute,
    input  wire logic [3:0]  edit_hour_tens,
    input  wire logic [3:0]  edit_hour_ones,
    input  wire logic [3:0]  edit_minute_tens,
    input  wire logic [3:0]  edit_minute_ones,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ringing,
    output logic             enabled,
    output logic [15:0]      alarm_display,
    output logic [15:0]      edit_display,
    output logic [2:0]       error_column,
    output logic             buzzer_start,
    output logic             buzzer_stop
);

    ace_item_t   in_item;
    ace_item_t   item;
    logic        item_valid;
    logic        take;
    ace_result_t result_next;
    ace_result_t result_out;

    // Pack the input fields
    always_comb
    begin
        in_item.command          = cmd_t'(command);
        in_item.now_ms           = now_ms;
        in_item.rtc_ok           = rtc_ok;
        in_item.current_hour     = current_hour;
        in_item.current_minute   = current_minute;
        in_item.edit_hour_tens   = edit_hour_tens;
        in_item.edit_hour_ones   = edit_hour_ones;
        in_item.edit_minute_tens = edit_minute_tens;
        in_item.edit_minute_ones = edit_minute_ones;
    end

    ace_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ace_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (item_valid && take),
        .item      (item),
        .result    (result_next)
    );

    ace_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result_in  (result_next),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_out)
    );

    // Unpack the result fields
    assign ringing       = result_out.ringing;
    assign enabled       = result_out.enabled;
    assign alarm_display = result_out.alarm_display;
    assign edit_display  = result_out.edit_display;
    assign error_column  = result_out.error_column;
    assign buzzer_start  = result_out.buzzer_start;
    assign buzzer_stop   = result_out.buzzer_stop;

    // A ringing alarm is always armed
    a_ring_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!ringing || enabled))
        else $error("ringing while disarmed");

    // Start and stop never pulse together, and a start means ringing
    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buzzer_start |-> (!buzzer_stop && ringing))
        else $error("bad buzzer pulse");

    // A rejected save changes nothing that would stop the sound
    a_err_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_column != ERR_NONE) |-> !buzzer_stop)
        else $error("stop pulse on rejected save");

    // A disarmed alarm shows a blank time
    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !enabled |-> (alarm_display == 16'd0))
        else $error("display not blank while disarmed");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the alarm compare and edit block
`default_nettype none

module tb
    import ace_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [31:0] now_ms = '0;
    logic        rtc_ok = 1'b0;
    logic [4:0]  current_hour = '0;
    logic [5:0]  current_minute = '0;
    logic [3:0]  edit_hour_tens = '0;
    logic [3:0]  edit_hour_ones = '0;
    logic [3:0]  edit_minute_tens = '0;
    logic [3:0]  edit_minute_ones = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ringing;
    logic        enabled;
    logic [15:0] alarm_display;
    logic [15:0] edit_display;
    logic [2:0]  error_column;
    logic        buzzer_start;
    logic        buzzer_stop;

    // Shadow of the alarm state, advanced once per accepted item
    logic [15:0] delay_ms = DELAY_RESET;
    logic [4:0]  alarm_hour = '0;
    logic [6:0]  alarm_minute = '0;
    logic        armed = 1'b0;
    logic        ring_flag = 1'b0;
    logic [10:0] last_trigger = NO_TRIGGER;
    logic [31:0] last_check_ms = '0;

    ace_result_t status_due[$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    logic [31:0] now_track = '0;

    alarm_compare_and_edit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .now_ms           (now_ms),
        .rtc_ok           (rtc_ok),
        .current_hour     (current_hour),
        .current_minute   (current_minute),
        .edit_hour_tens   (edit_hour_tens),
        .edit_hour_ones   (edit_hour_ones),
        .edit_minute_tens (edit_minute_tens),
        .edit_minute_ones (edit_minute_ones),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .ringing          (ringing),
        .enabled          (enabled),
        .alarm_display    (alarm_display),
        .edit_display     (edit_display),
        .error_column     (error_column),
        .buzzer_start     (buzzer_start),
        .buzzer_stop      (buzzer_stop)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advance the shadow state by one item and return the status it reports
    function automatic ace_result_t alarm_step(ace_item_t it);
        ace_result_t r;
        logic        zero_edit;
        logic        is24;
        logic [31:0] elapsed;
        logic [2:0]  err;
        int          clock_min;
        int          hh;
        int          mo_d;
        int          mt_d;
        int          ho_d;
        int          ht_d;
        r = '0;
        err = ERR_NONE;
        zero_edit = (it.edit_hour_tens | it.edit_hour_ones | it.edit_minute_tens
                     | it.edit_minute_ones) == 4'd0;
        is24 = (it.edit_hour_tens == 4'd2) && (it.edit_hour_ones == 4'd4);
        case (it.command)
            CMD_CHECK:
            begin
                elapsed = it.now_ms - last_check_ms;
                if (!ring_flag && armed && elapsed >= {16'd0, delay_ms})
                begin
                    last_check_ms = it.now_ms;
                    clock_min = it.current_hour * 60 + it.current_minute;
                    if (it.rtc_ok && clock_min[10:0] != last_trigger
                        && it.current_hour == alarm_hour
                        && {1'b0, it.current_minute} == alarm_minute)
                    begin
                        last_trigger = clock_min[10:0];
                        ring_flag = 1'b1;
                        r.buzzer_start = 1'b1;
                    end
                end
            end
            CMD_SAVE:
            begin
                if (it.edit_hour_tens > 4'd2)
                    err = ERR_HOUR_TENS;
                else if (it.edit_hour_ones > 4'd9
                         || (it.edit_hour_tens == 4'd2 && it.edit_hour_ones > 4'd4))
                    err = ERR_HOUR_ONES;
                else if (it.edit_minute_tens > 4'd5 || (is24 && it.edit_minute_tens != 4'd0))
                    err = ERR_MINUTE_TENS;
                else if (it.edit_minute_ones > 4'd9 || (is24 && it.edit_minute_ones != 4'd0))
                    err = ERR_MINUTE_ONES;
                r.error_column = err;
                if (err == ERR_NONE)
                begin
                    ring_flag = 1'b0;
                    r.buzzer_stop = 1'b1;
                    if (zero_edit)
                        armed = 1'b0;
                    else
                    begin
                        hh = it.edit_hour_tens * 10 + it.edit_hour_ones;
                        alarm_hour = (hh == 24) ? 5'd0 : hh[4:0];
                        alarm_minute = 7'(it.edit_minute_tens * 10 + it.edit_minute_ones);
                        armed = 1'b1;
                    end
                    last_trigger = NO_TRIGGER;
                end
            end
            CMD_DISABLE:
            begin
                alarm_hour = '0;
                alarm_minute = '0;
                armed = 1'b0;
                ring_flag = 1'b0;
                last_trigger = NO_TRIGGER;
                r.buzzer_stop = 1'b1;
            end
            default: ;
        endcase

        // Build displays from the updated state
        mo_d = alarm_minute % 10;
        mt_d = alarm_minute / 10;
        ho_d = alarm_hour % 10;
        ht_d = alarm_hour / 10;
        r.ringing = ring_flag;
        r.enabled = armed;
        r.alarm_display = armed ? {mo_d[3:0], mt_d[3:0], ho_d[3:0], ht_d[3:0]} : 16'd0;
        if (zero_edit)
            r.edit_display = armed ? 16'h0042 : 16'h0000;
        else
            r.edit_display = {it.edit_minute_ones, it.edit_minute_tens,
                              it.edit_hour_ones, it.edit_hour_tens};
        return r;
    endfunction

    function automatic ace_item_t make_item(cmd_t c, logic [31:0] now, logic ok,
                                            logic [4:0] h, logic [5:0] m, logic [15:0] digits);
        ace_item_t it;
        it.command = c;
        it.now_ms = now;
        it.rtc_ok = ok;
        it.current_hour = h;
        it.current_minute = m;
        {it.edit_hour_tens, it.edit_hour_ones, it.edit_minute_tens, it.edit_minute_ones}
            = digits;
        return it;
    endfunction

    // Edit digits as {hour tens, hour ones, minute tens, minute ones}
    function automatic logic [15:0] rand_digits(bit well_formed);
        int hh;
        int mm;
        if (!well_formed)
            return 16'($urandom());
        hh = $urandom_range(24);
        mm = (hh == 24) ? 0 : $urandom_range(59);
        if ($urandom_range(9) == 0)
        begin
            hh = 0;
            mm = 0;
        end
        return {4'(hh / 10), 4'(hh % 10), 4'(mm / 10), 4'(mm % 10)};
    endfunction

    // Mostly well-formed traffic steered toward the stored alarm time
    function automatic ace_item_t rand_item();
        ace_item_t it;
        int        pick;
        int        sel;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            now_track = $urandom();
        else
            now_track = now_track + $urandom_range(2 * delay_ms + 2);
        it = make_item(CMD_CHECK, now_track, $urandom_range(9) != 0, '0, '0,
                       rand_digits($urandom_range(3) != 0));
        if (pick < 50)
            it.command = CMD_CHECK;
        else if (pick < 70)
            it.command = CMD_SAVE;
        else if (pick < 75)
            it.command = CMD_DISABLE;
        else
            it.command = CMD_PREVIEW;
        sel = $urandom_range(9);
        if (sel < 6)
        begin
            it.current_hour = alarm_hour;
            it.current_minute = alarm_minute[5:0];
        end
        else if (sel < 8)
        begin
            it.current_hour = alarm_hour;
            it.current_minute = 6'($urandom_range(59));
        end
        else
        begin
            it.current_hour = 5'($urandom_range(31));
            it.current_minute = 6'($urandom_range(63));
        end
        return it;
    endfunction

    // Present one item, hold it until accepted, then record its status
    task automatic send_item(ace_item_t it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        command          <= it.command;
        now_ms           <= it.now_ms;
        rtc_ok           <= it.rtc_ok;
        current_hour     <= it.current_hour;
        current_minute   <= it.current_minute;
        edit_hour_tens   <= it.edit_hour_tens;
        edit_hour_ones   <= it.edit_hour_ones;
        edit_minute_tens <= it.edit_minute_tens;
        edit_minute_ones <= it.edit_minute_ones;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        status_due.push_back(alarm_step(it));
    endtask

    // Drop valid and hold until every pending status has come back
    task automatic drain_pending();
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_delay(logic [15:0] value);
        drain_pending();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        delay_ms = value;
    endtask

    task automatic test_after_reset();
        send_item(make_item(CMD_PREVIEW, 32'd0, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_CHECK, 32'd5000, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_PREVIEW, 32'd0, 1'b0, 5'd31, 6'd63, 16'hFFFF));
    endtask

    // At least one bad digit column per save, including the 24 hour limits
    task automatic test_save_errors();
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h3000));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'hF999));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h1A00));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h2500));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h1260));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h2410));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h125A));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h2401));
    endtask

    // Midnight alarm, update delay, disarm by 00:00, tick wraparound, bad clock read
    task automatic test_ring_and_wrap();
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h2400));
        send_item(make_item(CMD_CHECK, 32'd999, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_CHECK, 32'd1000, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_CHECK, 32'd9000, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_PREVIEW, 32'd0, 1'b1, 5'd0, 6'd0, 16'h0000));
        send_item(make_item(CMD_SAVE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h1234));
        send_item(make_item(CMD_CHECK, 32'hFFFF_FF00, 1'b1, 5'd31, 6'd63, 16'h0000));
        send_item(make_item(CMD_CHECK, 32'h0000_0100, 1'b1, 5'd12, 6'd34, 16'h0000));
        send_item(make_item(CMD_CHECK, 32'h0000_0400, 1'b0, 5'd12, 6'd34, 16'h0000));
        send_item(make_item(CMD_CHECK, 32'h0000_0800, 1'b1, 5'd12, 6'd34, 16'h0000));
        send_item(make_item(CMD_DISABLE, 32'd0, 1'b1, 5'd0, 6'd0, 16'h1234));
    endtask

    task automatic test_random_traffic(int send_idle, int recv_stall, logic [15:0] delay,
                                       int count, bit pause_midway);
        write_delay(delay);
        idle_pct = send_idle;
        stall_pct = recv_stall;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                drain_pending();
            send_item(rand_item());
        end
    endtask

    // Stall the result channel at the current rate
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Compare each accepted status with the oldest pending one
    always @(posedge clk)
    begin : status_check
        ace_result_t got;
        ace_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {ringing, enabled, alarm_display, edit_display, error_column,
                   buzzer_start, buzzer_stop};
            if (status_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: status with no item pending: %h", $realtime, got);
            end
            else
            begin
                want = status_due.pop_front();
                if (got.ringing !== want.ringing || got.enabled !== want.enabled
                    || got.alarm_display !== want.alarm_display
                    || got.edit_display !== want.edit_display
                    || got.error_column !== want.error_column
                    || got.buzzer_start !== want.buzzer_start
                    || got.buzzer_stop !== want.buzzer_stop)
                begin
                    mismatches++;
                    // Fields: ring, en, alarm, edit, err, start, stop
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: exp %b %b %h %h %0d %b %b got %b %b %h %h %0d %b %b",
                                 $realtime, want.ringing, want.enabled, want.alarm_display,
                                 want.edit_display, want.error_column, want.buzzer_start,
                                 want.buzzer_stop, got.ringing, got.enabled,
                                 got.alarm_display, got.edit_display, got.error_column,
                                 got.buzzer_start, got.buzzer_stop);
                end
            end
        end
    end

    // End the run after too long without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_save_errors();
        test_ring_and_wrap();

        test_random_traffic(0, 0, 16'd0, 100, 1'b0);
        test_random_traffic(77, 0, 16'hFFFF, 100, 1'b0);
        test_random_traffic(0, 77, 16'($urandom_range(1, 5000)), 100, 1'b1);
        test_random_traffic(28, 28, DELAY_RESET, 100, 1'b0);

        drain_pending();
        repeat (10) @(posedge clk);
        mismatches += status_due.size();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
